[hdl/pcbwm_pkg.sv]
// ----------------------------------------------------------------------------
// pcbwm_pkg
// shared types and constants of the per-class block window maximum
// ----------------------------------------------------------------------------
package pcbwm_pkg;

    localparam int CLASS_W = 3;
    localparam int COORD_W = 10;
    localparam int AGE_W   = 8;
    localparam int AREA_W  = 20;
    localparam int MASK_W  = 7;
    localparam int WLEN_W  = 5;

    typedef enum logic [1:0] {
        OP_BLOCK = 2'd0,
        OP_EOF   = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_CLASS_MASK = 1'b0,
        REG_WINDOW_LEN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EOF,
        ST_SCAN,
        ST_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [AGE_W-1:0]   age;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } blob_t;

    typedef struct packed {
        op_t                op;
        logic               cls_ok;
        logic [CLASS_W-1:0] cls_raw;
        logic [CLASS_W-1:0] cls_idx;
        blob_t              blk;
        logic [AREA_W-1:0]  area;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [CLASS_W-1:0] best_class;
        blob_t              blk;
        logic [AREA_W-1:0]  area;
    } res_t;

    typedef struct packed {
        logic [MASK_W-1:0] class_mask;
        logic [WLEN_W-1:0] window_len;
        logic              wl_wr;
        logic [WLEN_W-1:0] wl_new;
    } cfg_t;

endpackage

[hdl/pcbwm_fifo.sv]
// ----------------------------------------------------------------------------
// pcbwm_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module pcbwm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/pcbwm_front.sv]
// ----------------------------------------------------------------------------
// pcbwm_front
// accepts input items, checks the class and computes the block area
// ----------------------------------------------------------------------------
module pcbwm_front #(
    parameter int NUM_CLASSES = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      operation,
    input  logic [pcbwm_pkg::CLASS_W-1:0]   class_id,
    input  logic [pcbwm_pkg::COORD_W-1:0]   pos_x,
    input  logic [pcbwm_pkg::COORD_W-1:0]   pos_y,
    input  logic [pcbwm_pkg::COORD_W-1:0]   blob_width,
    input  logic [pcbwm_pkg::COORD_W-1:0]   blob_height,
    input  logic [pcbwm_pkg::AGE_W-1:0]     track_age,
    output logic                            cmd_push,
    input  logic                            cmd_full,
    output pcbwm_pkg::cmd_t                 cmd_data
);

    logic            valid_reg, valid_next;
    pcbwm_pkg::cmd_t cmd_reg;
    pcbwm_pkg::cmd_t cmd_in;
    logic            accept;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = valid_reg;
    assign cmd_data = cmd_reg;

    always_comb
    begin
        cmd_in.op      = pcbwm_pkg::op_t'(operation);
        cmd_in.cls_ok  = (class_id != '0) &&
                         (class_id <= pcbwm_pkg::CLASS_W'(NUM_CLASSES));
        cmd_in.cls_raw = class_id;
        cmd_in.cls_idx = class_id - 1'b1;
        cmd_in.blk.x   = pos_x;
        cmd_in.blk.y   = pos_y;
        cmd_in.blk.w   = blob_width;
        cmd_in.blk.h   = blob_height;
        cmd_in.blk.age = track_age;
        cmd_in.area    = pcbwm_pkg::AREA_W'(blob_width) * pcbwm_pkg::AREA_W'(blob_height);
        valid_next     = accept || (valid_reg && cmd_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_in;
        end
    end

endmodule

[hdl/pcbwm_back.sv]
// ----------------------------------------------------------------------------
// pcbwm_back
// frame accumulators, per-class rings in a memory and the query scan
// ----------------------------------------------------------------------------
module pcbwm_back #(
    parameter int NUM_CLASSES  = 7,
    parameter int WINDOW_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    input  pcbwm_pkg::cmd_t cmd_data,
    output logic            cmd_pop,
    input  logic            res_full,
    output logic            res_push,
    output pcbwm_pkg::res_t res_data,
    input  pcbwm_pkg::cfg_t cfg
);

    localparam int RING_SIZE = NUM_CLASSES * WINDOW_DEPTH;
    localparam int AW        = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int PW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNTW      = $clog2(WINDOW_DEPTH + 1);
    localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEMW      = pcbwm_pkg::AREA_W + $bits(pcbwm_pkg::blob_t);
    localparam logic [AW-1:0] WD_A = AW'(WINDOW_DEPTH);

    pcbwm_pkg::back_state_t state_reg, state_next;

    logic                          acc_found_reg [NUM_CLASSES];
    logic                          acc_found_next [NUM_CLASSES];
    pcbwm_pkg::blob_t              acc_blk_reg [NUM_CLASSES];
    pcbwm_pkg::blob_t              acc_blk_next [NUM_CLASSES];
    logic [pcbwm_pkg::AREA_W-1:0]  acc_area_reg [NUM_CLASSES];
    logic [pcbwm_pkg::AREA_W-1:0]  acc_area_next [NUM_CLASSES];
    logic [PW-1:0]                 head_reg [NUM_CLASSES];
    logic [PW-1:0]                 head_next [NUM_CLASSES];
    logic [CNTW-1:0]               count_reg [NUM_CLASSES];
    logic [CNTW-1:0]               count_next [NUM_CLASSES];
    logic [RING_SIZE-1:0]          ring_valid_reg, ring_valid_next;

    logic [MEMW-1:0]               ring_mem [RING_SIZE];
    logic [MEMW-1:0]               rd_data_reg;
    logic                          rd_vld_reg;
    logic                          rd_live_reg;

    logic [CW-1:0]                 eof_idx_reg, eof_idx_next;
    logic [CW-1:0]                 scan_cls_reg, scan_cls_next;
    logic [pcbwm_pkg::CLASS_W-1:0] scan_raw_reg, scan_raw_next;
    logic [PW-1:0]                 scan_ptr_reg, scan_ptr_next;
    logic [CNTW-1:0]               remain_reg, remain_next;
    logic                          best_found_reg, best_found_next;
    pcbwm_pkg::blob_t              best_blk_reg, best_blk_next;
    logic [pcbwm_pkg::AREA_W-1:0]  best_area_reg, best_area_next;

    logic [NUM_CLASSES-1:0]        mask_nc;
    logic [CW-1:0]                 cur_c;
    logic                          go;
    logic                          start_scan;
    logic                          mem_we;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    pcbwm_pkg::blob_t              rd_blk;
    logic [pcbwm_pkg::AREA_W-1:0]  rd_area;

    assign mask_nc    = cfg.class_mask[NUM_CLASSES-1:0];
    assign cur_c      = (state_reg == pcbwm_pkg::ST_EOF) ? eof_idx_reg : CW'(cmd_data.cls_idx);
    assign go         = (state_reg == pcbwm_pkg::ST_IDLE) && !cmd_empty &&
                        ((cmd_data.op != pcbwm_pkg::OP_QUERY) || !res_full);
    assign start_scan = cmd_data.cls_ok && (count_reg[cur_c] != '0);
    assign rd_blk     = rd_data_reg[$bits(pcbwm_pkg::blob_t)-1:0];
    assign rd_area    = rd_data_reg[MEMW-1:$bits(pcbwm_pkg::blob_t)];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcbwm_pkg::ST_IDLE:
            begin
                if (go && (cmd_data.op == pcbwm_pkg::OP_EOF))
                begin
                    state_next = pcbwm_pkg::ST_EOF;
                end
                else if (go && (cmd_data.op == pcbwm_pkg::OP_QUERY) && start_scan)
                begin
                    state_next = pcbwm_pkg::ST_SCAN;
                end
            end
            pcbwm_pkg::ST_EOF:
            begin
                if (eof_idx_reg == CW'(NUM_CLASSES - 1))
                begin
                    state_next = pcbwm_pkg::ST_IDLE;
                end
            end
            pcbwm_pkg::ST_SCAN:
            begin
                if (remain_reg == CNTW'(1))
                begin
                    state_next = pcbwm_pkg::ST_DRAIN;
                end
            end
            pcbwm_pkg::ST_DRAIN:
            begin
                state_next = pcbwm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcbwm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = go;
        res_push = (go && (cmd_data.op == pcbwm_pkg::OP_QUERY) && !start_scan) ||
                   (state_reg == pcbwm_pkg::ST_DRAIN);
        res_data = '0;
        if ((state_reg == pcbwm_pkg::ST_DRAIN) && best_found_next)
        begin
            res_data.found      = 1'b1;
            res_data.best_class = scan_raw_reg;
            res_data.blk        = best_blk_next;
            res_data.area       = best_area_next;
        end
        mem_we  = (state_reg == pcbwm_pkg::ST_EOF) && mask_nc[cur_c];
        wr_addr = AW'(cur_c) * WD_A + AW'(head_reg[cur_c]);
        rd_addr = AW'(scan_cls_reg) * WD_A + AW'(scan_ptr_reg);
    end

    // datapath
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            acc_found_next[c] = acc_found_reg[c];
            acc_blk_next[c]   = acc_blk_reg[c];
            acc_area_next[c]  = acc_area_reg[c];
            head_next[c]      = head_reg[c];
            count_next[c]     = count_reg[c];
        end
        ring_valid_next = ring_valid_reg;
        eof_idx_next    = eof_idx_reg;
        scan_cls_next   = scan_cls_reg;
        scan_raw_next   = scan_raw_reg;
        scan_ptr_next   = scan_ptr_reg;
        remain_next     = remain_reg;
        best_found_next = best_found_reg;
        best_blk_next   = best_blk_reg;
        best_area_next  = best_area_reg;

        if (go)
        begin
            case (cmd_data.op)
                pcbwm_pkg::OP_BLOCK:
                begin
                    if (cmd_data.cls_ok && mask_nc[cur_c] &&
                        (!acc_found_reg[cur_c] || (cmd_data.area > acc_area_reg[cur_c])))
                    begin
                        acc_found_next[cur_c] = 1'b1;
                        acc_blk_next[cur_c]   = cmd_data.blk;
                        acc_area_next[cur_c]  = cmd_data.area;
                    end
                end
                pcbwm_pkg::OP_EOF:
                begin
                    eof_idx_next = '0;
                end
                pcbwm_pkg::OP_QUERY:
                begin
                    if (start_scan)
                    begin
                        scan_cls_next   = cur_c;
                        scan_raw_next   = cmd_data.cls_raw;
                        scan_ptr_next   = (head_reg[cur_c] == '0) ?
                                          PW'(WINDOW_DEPTH - 1) : head_reg[cur_c] - 1'b1;
                        remain_next     = count_reg[cur_c];
                        best_found_next = 1'b0;
                    end
                end
                default:
                begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        if ((cmd_data.cls_raw == '0) ||
                            (cmd_data.cls_ok && (CW'(c) == cur_c)))
                        begin
                            head_next[c]  = '0;
                            count_next[c] = '0;
                            for (int k = 0; k < WINDOW_DEPTH; k++)
                            begin
                                ring_valid_next[c * WINDOW_DEPTH + k] = 1'b0;
                            end
                        end
                    end
                end
            endcase
        end

        if (state_reg == pcbwm_pkg::ST_EOF)
        begin
            if (mask_nc[cur_c])
            begin
                ring_valid_next[wr_addr] = acc_found_reg[cur_c];
                head_next[cur_c] = (head_reg[cur_c] == PW'(WINDOW_DEPTH - 1)) ?
                                   '0 : head_reg[cur_c] + 1'b1;
                if (8'(count_reg[cur_c]) < 8'(cfg.window_len))
                begin
                    count_next[cur_c] = count_reg[cur_c] + 1'b1;
                end
            end
            eof_idx_next = eof_idx_reg + 1'b1;
            if (eof_idx_reg == CW'(NUM_CLASSES - 1))
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    acc_found_next[c] = 1'b0;
                    acc_blk_next[c]   = '0;
                    acc_area_next[c]  = '0;
                end
            end
        end

        if (state_reg == pcbwm_pkg::ST_SCAN)
        begin
            scan_ptr_next = (scan_ptr_reg == '0) ? PW'(WINDOW_DEPTH - 1) : scan_ptr_reg - 1'b1;
            remain_next   = remain_reg - 1'b1;
        end

        // newest first, so a later equal area does not replace
        if (rd_live_reg && rd_vld_reg && (!best_found_reg || (rd_area > best_area_reg)))
        begin
            best_found_next = 1'b1;
            best_blk_next   = rd_blk;
            best_area_next  = rd_area;
        end

        if (cfg.wl_wr)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (8'(count_reg[c]) > 8'(cfg.wl_new))
                begin
                    count_next[c] = CNTW'(cfg.wl_new);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcbwm_pkg::ST_IDLE;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                acc_found_reg[c] <= 1'b0;
                acc_blk_reg[c]   <= '0;
                acc_area_reg[c]  <= '0;
                head_reg[c]      <= '0;
                count_reg[c]     <= '0;
            end
            ring_valid_reg <= '0;
            eof_idx_reg    <= '0;
            remain_reg     <= '0;
            best_found_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                acc_found_reg[c] <= acc_found_next[c];
                acc_blk_reg[c]   <= acc_blk_next[c];
                acc_area_reg[c]  <= acc_area_next[c];
                head_reg[c]      <= head_next[c];
                count_reg[c]     <= count_next[c];
            end
            ring_valid_reg <= ring_valid_next;
            eof_idx_reg    <= eof_idx_next;
            remain_reg     <= remain_next;
            best_found_reg <= best_found_next;
            rd_live_reg    <= (state_reg == pcbwm_pkg::ST_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cls_reg  <= scan_cls_next;
        scan_raw_reg  <= scan_raw_next;
        scan_ptr_reg  <= scan_ptr_next;
        best_blk_reg  <= best_blk_next;
        best_area_reg <= best_area_next;
        rd_vld_reg    <= ring_valid_reg[rd_addr];
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_addr] <= {acc_area_reg[cur_c], acc_blk_reg[cur_c]};
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

endmodule

[hdl/per_class_blob_window_max.sv]
// ----------------------------------------------------------------------------
// per_class_blob_window_max
// per-class sliding-window maximum of detected blocks
// ----------------------------------------------------------------------------
// items enter through push/full; a transfer happens when push is high and
// full is low. results leave through empty/pop; the oldest result sits on the
// result ports while empty is low and goes with pop.
// the front stage registers each item and its width*height, a two-entry
// command queue feeds the back stage, and a two-entry result queue sits on
// the output, so the input keeps flowing while a result waits.
// in the back stage, block and clear are done at issue; end of frame issues, then
// makes one ring write per enabled class; a query issues, makes one ring read per
// kept frame, then a drain step for the memory read register. a query on an
// empty window or an invalid class is answered at issue, without a scan. each item
// passes the front register and the command queue, and its result the result queue.
// when pop stays low the result queue fills, the back stage holds queries,
// and full rises once the command queue and front register are taken.
// reset empties all queues, accumulators and rings; class_mask resets to all
// classes and window_len to the window depth, at most 16. configuration is
// written over the apb port, class_mask at byte 0 and window_len at byte 4.
// ----------------------------------------------------------------------------
module per_class_blob_window_max #(
    parameter int NUM_CLASSES  = 7,
    parameter int WINDOW_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [2:0]  class_id,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [9:0]  blob_width,
    input  logic [9:0]  blob_height,
    input  logic [7:0]  track_age,
    output logic        empty,
    input  logic        pop,
    output logic        found,
    output logic [2:0]  best_class,
    output logic [9:0]  best_x,
    output logic [9:0]  best_y,
    output logic [9:0]  best_width,
    output logic [9:0]  best_height,
    output logic [19:0] best_area,
    output logic [7:0]  best_age,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] WL_RESET = 5'((WINDOW_DEPTH < 16) ? WINDOW_DEPTH : 16);

    logic [pcbwm_pkg::MASK_W-1:0] class_mask_reg, class_mask_next;
    logic [pcbwm_pkg::WLEN_W-1:0] window_len_reg, window_len_next;
    logic [pcbwm_pkg::WLEN_W-1:0] wl_clamped;
    logic                         cfg_wr;
    pcbwm_pkg::cfg_t              cfg;

    logic                         cmd_push;
    logic                         cmd_full;
    pcbwm_pkg::cmd_t              cmd_front;
    logic                         cmd_pop;
    logic                         cmd_empty;
    pcbwm_pkg::cmd_t              cmd_back;
    logic                         res_push;
    logic                         res_full;
    pcbwm_pkg::res_t              res_back;
    pcbwm_pkg::res_t              res_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        wl_clamped = pwdata[pcbwm_pkg::WLEN_W-1:0];
        if (wl_clamped == '0)
        begin
            wl_clamped = 5'd1;
        end
        else if (8'(wl_clamped) > 8'(WINDOW_DEPTH))
        begin
            wl_clamped = 5'(WINDOW_DEPTH);
        end
    end

    always_comb
    begin
        class_mask_next = class_mask_reg;
        window_len_next = window_len_reg;
        cfg.wl_wr       = 1'b0;
        prdata          = '0;
        unique case (pcbwm_pkg::reg_idx_t'(paddr[2]))
            pcbwm_pkg::REG_CLASS_MASK:
            begin
                prdata = {25'b0, class_mask_reg};
                if (cfg_wr)
                begin
                    class_mask_next = pwdata[pcbwm_pkg::MASK_W-1:0];
                end
            end
            pcbwm_pkg::REG_WINDOW_LEN:
            begin
                prdata = {27'b0, window_len_reg};
                if (cfg_wr)
                begin
                    window_len_next = wl_clamped;
                    cfg.wl_wr       = 1'b1;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
        cfg.class_mask = class_mask_reg;
        cfg.window_len = window_len_reg;
        cfg.wl_new     = wl_clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_mask_reg <= 7'h7F;
            window_len_reg <= WL_RESET;
        end
        else
        begin
            class_mask_reg <= class_mask_next;
            window_len_reg <= window_len_next;
        end
    end

    pcbwm_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .class_id    (class_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .blob_width  (blob_width),
        .blob_height (blob_height),
        .track_age   (track_age),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd_data    (cmd_front)
    );

    pcbwm_fifo #(
        .WIDTH ($bits(pcbwm_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .full    (cmd_full),
        .wr_data (cmd_front),
        .pop     (cmd_pop),
        .empty   (cmd_empty),
        .rd_data (cmd_back)
    );

    pcbwm_back #(
        .NUM_CLASSES  (NUM_CLASSES),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_back),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_back),
        .cfg       (cfg)
    );

    pcbwm_fifo #(
        .WIDTH ($bits(pcbwm_pkg::res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res_back),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res_out)
    );

    assign found       = res_out.found;
    assign best_class  = res_out.best_class;
    assign best_x      = res_out.blk.x;
    assign best_y      = res_out.blk.y;
    assign best_width  = res_out.blk.w;
    assign best_height = res_out.blk.h;
    assign best_area   = res_out.area;
    assign best_age    = res_out.blk.age;

`ifndef SYNTH
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_res_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("pushed result not visible");

    a_window_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_len_reg != '0) && (8'(window_len_reg) <= 8'(WINDOW_DEPTH)))
        else $error("window_len out of range");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench of the per-class block window maximum
// ----------------------------------------------------------------------------
// items go in through push/full and query answers come back through
// empty/pop. a behavioral copy of the accumulators, the per-class rings and
// the two registers predicts every answer when its item is accepted. each
// answer that is popped is compared field by field with the oldest
// prediction. a directed sequence comes first, then frames under several
// register settings, then random frames with idle and stall at random on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_CLASSES = 7;
    localparam int DEPTH     = 16;
    localparam int PAUSE     = 40;
    localparam int LIMIT     = 5000;

    typedef struct packed {
        pcbwm_pkg::op_t                op;
        logic [pcbwm_pkg::CLASS_W-1:0] cls;
        pcbwm_pkg::blob_t              blk;
    } detect_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  operation = '0;
    logic [2:0]  class_id = '0;
    logic [9:0]  pos_x = '0;
    logic [9:0]  pos_y = '0;
    logic [9:0]  blob_width = '0;
    logic [9:0]  blob_height = '0;
    logic [7:0]  track_age = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        found;
    logic [2:0]  best_class;
    logic [9:0]  best_x;
    logic [9:0]  best_y;
    logic [9:0]  best_width;
    logic [9:0]  best_height;
    logic [19:0] best_area;
    logic [7:0]  best_age;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predicted state
    logic [pcbwm_pkg::MASK_W-1:0] mask_q;
    int                           wlen_q;
    bit                           acc_seen [N_CLASSES];
    pcbwm_pkg::blob_t             acc_blob [N_CLASSES];
    logic [pcbwm_pkg::AREA_W-1:0] acc_size [N_CLASSES];
    bit                           hist_valid [N_CLASSES][DEPTH];
    pcbwm_pkg::blob_t             hist_blob [N_CLASSES][DEPTH];
    logic [pcbwm_pkg::AREA_W-1:0] hist_size [N_CLASSES][DEPTH];
    int                           hist_head [N_CLASSES];
    int                           hist_count [N_CLASSES];

    pcbwm_pkg::res_t pending_best [$];
    int              mismatches = 0;
    int              items_sent = 0;
    int              idle_pct = 0;
    int              stall_pct = 0;
    int              quiet_cycles = 0;

    per_class_blob_window_max #(
        .NUM_CLASSES  (N_CLASSES),
        .WINDOW_DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .class_id    (class_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .blob_width  (blob_width),
        .blob_height (blob_height),
        .track_age   (track_age),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .best_class  (best_class),
        .best_x      (best_x),
        .best_y      (best_y),
        .best_width  (best_width),
        .best_height (best_height),
        .best_area   (best_area),
        .best_age    (best_age),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_history(input int c);
        hist_head[c] = 0;
        hist_count[c] = 0;
        for (int k = 0; k < DEPTH; k++)
            hist_valid[c][k] = 1'b0;
    endfunction

    function automatic void reset_history();
        mask_q = 7'h7F;
        wlen_q = DEPTH;
        for (int c = 0; c < N_CLASSES; c++)
        begin
            acc_seen[c] = 1'b0;
            acc_blob[c] = '0;
            acc_size[c] = '0;
            clear_history(c);
        end
    endfunction

    // returns 1 when the item produces an answer
    function automatic bit track_item(input detect_t it, output pcbwm_pkg::res_t r);
        int                           c;
        int                           pos;
        bit                           hit;
        logic [pcbwm_pkg::AREA_W-1:0] wv;
        logic [pcbwm_pkg::AREA_W-1:0] hv;
        logic [pcbwm_pkg::AREA_W-1:0] size;
        logic [pcbwm_pkg::AREA_W-1:0] best;
        pcbwm_pkg::blob_t             pick;
        r = '0;
        wv = pcbwm_pkg::AREA_W'(it.blk.w);
        hv = pcbwm_pkg::AREA_W'(it.blk.h);
        size = wv * hv;
        case (it.op)
            pcbwm_pkg::OP_BLOCK:
            begin
                if (it.cls != 0 && it.cls <= N_CLASSES)
                begin
                    c = it.cls - 1;
                    if (mask_q[c] && (!acc_seen[c] || size > acc_size[c]))
                    begin
                        acc_seen[c] = 1'b1;
                        acc_size[c] = size;
                        acc_blob[c] = it.blk;
                    end
                end
                return 1'b0;
            end
            pcbwm_pkg::OP_EOF:
            begin
                for (c = 0; c < N_CLASSES; c++)
                begin
                    if (mask_q[c])
                    begin
                        pos = hist_head[c];
                        hist_valid[c][pos] = acc_seen[c];
                        hist_blob[c][pos] = acc_seen[c] ? acc_blob[c] : '0;
                        hist_size[c][pos] = acc_seen[c] ? acc_size[c] : '0;
                        hist_head[c] = (hist_head[c] + 1) % DEPTH;
                        if (hist_count[c] < wlen_q)
                            hist_count[c]++;
                    end
                    acc_seen[c] = 1'b0;
                    acc_blob[c] = '0;
                    acc_size[c] = '0;
                end
                return 1'b0;
            end
            pcbwm_pkg::OP_CLEAR:
            begin
                if (it.cls == 0)
                begin
                    for (c = 0; c < N_CLASSES; c++)
                        clear_history(c);
                end
                else if (it.cls <= N_CLASSES)
                begin
                    clear_history(it.cls - 1);
                end
                return 1'b0;
            end
            default:
            begin
                hit = 1'b0;
                best = '0;
                pick = '0;
                if (it.cls != 0 && it.cls <= N_CLASSES)
                begin
                    c = it.cls - 1;
                    for (int i = 0; i < hist_count[c]; i++)
                    begin
                        pos = (hist_head[c] + DEPTH - 1 - i) % DEPTH;
                        if (hist_valid[c][pos] && (!hit || hist_size[c][pos] > best))
                        begin
                            hit = 1'b1;
                            best = hist_size[c][pos];
                            pick = hist_blob[c][pos];
                        end
                    end
                end
                if (hit)
                begin
                    r.found = 1'b1;
                    r.best_class = it.cls;
                    r.blk = pick;
                    r.area = best;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_best();
        pcbwm_pkg::res_t want;
        if (pending_best.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none actual found=%0d class=%0d area=%0d",
                     $time, found, best_class, best_area);
            return;
        end
        want = pending_best.pop_front();
        check_field("found", 32'(want.found), 32'(found));
        check_field("best_class", 32'(want.best_class), 32'(best_class));
        check_field("best_x", 32'(want.blk.x), 32'(best_x));
        check_field("best_y", 32'(want.blk.y), 32'(best_y));
        check_field("best_width", 32'(want.blk.w), 32'(best_width));
        check_field("best_height", 32'(want.blk.h), 32'(best_height));
        check_field("best_area", 32'(want.area), 32'(best_area));
        check_field("best_age", 32'(want.blk.age), 32'(best_age));
    endfunction

    // result side, receiver stall and watchdog
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_best();
        pop <= ($urandom_range(99) >= stall_pct);
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= LIMIT)
            begin
                $display("per_class_blob_window_max test failed");
                $finish;
            end
        end
    end

    function automatic detect_t make_item(input pcbwm_pkg::op_t op, input int cls,
                                          input int x, input int y, input int w,
                                          input int h, input int age);
        detect_t it;
        it.op = op;
        it.cls = pcbwm_pkg::CLASS_W'(cls);
        it.blk.x = pcbwm_pkg::COORD_W'(x);
        it.blk.y = pcbwm_pkg::COORD_W'(y);
        it.blk.w = pcbwm_pkg::COORD_W'(w);
        it.blk.h = pcbwm_pkg::COORD_W'(h);
        it.blk.age = pcbwm_pkg::AGE_W'(age);
        return it;
    endfunction

    function automatic detect_t rand_item(input pcbwm_pkg::op_t op, input int cls);
        int lim;
        lim = ($urandom_range(2) == 0) ? 7 : 1023;
        return make_item(op, cls, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(lim), $urandom_range(lim), $urandom_range(255));
    endfunction

    task automatic send_item(input detect_t it);
        pcbwm_pkg::res_t r;
        push <= 1'b1;
        operation <= it.op;
        class_id <= it.cls;
        pos_x <= it.blk.x;
        pos_y <= it.blk.y;
        blob_width <= it.blk.w;
        blob_height <= it.blk.h;
        track_age <= it.blk.age;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        if (track_item(it, r))
            pending_best.push_back(r);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_best.size() != 0)
            @(posedge clk);
        repeat (PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input pcbwm_pkg::reg_idx_t idx, input logic [31:0] value);
        int wl;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == pcbwm_pkg::REG_CLASS_MASK)
        begin
            mask_q = value[pcbwm_pkg::MASK_W-1:0];
        end
        else
        begin
            wl = int'(value[pcbwm_pkg::WLEN_W-1:0]);
            if (wl < 1)
                wl = 1;
            if (wl > DEPTH)
                wl = DEPTH;
            wlen_q = wl;
            for (int c = 0; c < N_CLASSES; c++)
                if (hist_count[c] > wlen_q)
                    hist_count[c] = wlen_q;
        end
    endtask

    // frames of blocks closed by end of frame and mostly followed by a query
    task automatic run_traffic(input int n_items);
        int target;
        int cls;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(rand_item(pcbwm_pkg::op_t'($urandom_range(3)), $urandom_range(7)));
            end
            else
            begin
                repeat ($urandom_range(0, 4))
                begin
                    cls = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, N_CLASSES);
                    send_item(rand_item(pcbwm_pkg::OP_BLOCK, cls));
                end
                if ($urandom_range(19) == 0)
                    send_item(rand_item(pcbwm_pkg::OP_CLEAR, $urandom_range(7)));
                send_item(rand_item(pcbwm_pkg::OP_EOF, $urandom_range(7)));
                if ($urandom_range(99) < 70)
                    send_item(rand_item(pcbwm_pkg::OP_QUERY, $urandom_range(7)));
            end
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_item(make_item(pcbwm_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 0, 1023, 1023, 1023, 1023, 255));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 1, 1023, 1023, 1023, 1023, 255));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 1, 0, 0, 1023, 1023, 0));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 1, 5, 5, 2, 2, 1));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 2, 1, 2, 0, 0, 3));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 2, 4, 4, 0, 5, 9));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 0, 7, 7, 900, 900, 77));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 7, 100, 200, 30, 40, 7));
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 7, 101, 201, 40, 30, 8));
        send_item(make_item(pcbwm_pkg::OP_EOF, 0, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 2, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 3, 0, 0, 0, 0, 0));
        // same area in a newer frame takes over
        send_item(make_item(pcbwm_pkg::OP_BLOCK, 1, 512, 256, 1023, 1023, 128));
        send_item(make_item(pcbwm_pkg::OP_EOF, 5, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_CLEAR, 1, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 7, 0, 0, 0, 0, 0));
        send_item(make_item(pcbwm_pkg::OP_QUERY, 2, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_register_settings();
        logic [pcbwm_pkg::MASK_W-1:0] masks [6];
        int                           lens [6];
        idle_pct = 21;
        stall_pct = 21;
        masks = '{7'h7F, 7'h00, 7'h55, 7'h2A, 7'h7F, 7'h7F};
        lens = '{1, 16, 5, 16, 3, 16};
        masks[4] = 7'($urandom_range(127));
        lens[4] = $urandom_range(1, DEPTH);
        write_reg(pcbwm_pkg::REG_CLASS_MASK, 32'h7F);
        write_reg(pcbwm_pkg::REG_WINDOW_LEN, DEPTH);
        run_traffic(60);
        for (int s = 0; s < 6; s++)
        begin
            wait_drained();
            write_reg(pcbwm_pkg::REG_CLASS_MASK, 32'(masks[s]));
            write_reg(pcbwm_pkg::REG_WINDOW_LEN, lens[s]);
            run_traffic(40);
        end
        wait_drained();
    endtask

    task automatic test_random_frames();
        int in_pct [4];
        int out_pct [4];
        in_pct = '{0, 59, 0, 21};
        out_pct = '{0, 0, 59, 21};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = in_pct[p];
            stall_pct = out_pct[p];
            run_traffic(130);
        end
        wait_drained();
    endtask

    initial
    begin
        reset_history();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_settings();
        test_random_frames();
        if (mismatches == 0 && pending_best.size() == 0)
        begin
            $display("per_class_blob_window_max test passed");
        end
        else
        begin
            if (pending_best.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_best.size());
            $display("per_class_blob_window_max test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/pcbwm_pkg.sv
hdl/pcbwm_fifo.sv
hdl/pcbwm_front.sv
hdl/pcbwm_back.sv
hdl/per_class_blob_window_max.sv
tb/tb_top.sv
